FILE: sv/asm_pkg.sv
package asm_pkg;

  localparam int unsigned LseW  = 24;
  localparam int unsigned ValW  = 32;
  localparam int unsigned Frac  = 16;
  localparam int unsigned DenW  = Frac + 9;
  localparam int unsigned SumW  = ValW + 9;
  localparam int unsigned NumW  = SumW + Frac;
  localparam int unsigned DataW = LseW + ValW;

  localparam logic signed [LseW-1:0] LseNegInf = {1'b1, {(LseW-1){1'b0}}};
  localparam logic signed [LseW-1:0] LsePosMax = {1'b0, {(LseW-1){1'b1}}};
  localparam logic [30:0] Q30One = 31'h4000_0000;
  localparam logic [16:0] QOne   = 17'h1_0000;

  typedef logic [30:0] coef_arr_t [Frac];

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] bit_v;
    res = '0;
    rem = n;
    for (int i = 31; i >= 0; i--) begin
      bit_v = 64'd1 << (2 * i);
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  function automatic coef_arr_t gen_coef();
    coef_arr_t arr;
    logic [63:0] c;
    c = isqrt(64'd1 << 59);
    for (int k = 0; k < Frac; k++) begin
      arr[k] = c[30:0];
      c = isqrt(c << 30);
    end
    return arr;
  endfunction

  localparam coef_arr_t ExpCoef = gen_coef();

endpackage

FILE: sv/asm_mul.sv
module asm_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);
  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;
endmodule

FILE: sv/asm_div.sv
module asm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [asm_pkg::NumW-1:0]      num_i,
  input  logic [asm_pkg::DenW-1:0]      den_i,
  output logic                          busy_o,
  output logic [asm_pkg::NumW-1:0]      quo_o
);
  import asm_pkg::*;

  logic            busy_q, busy_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   rem_sh;
  logic            fits;

  assign rem_sh = {rem_q, quo_q[NumW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'(NumW - 1);
      quo_d  = num_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? DenW'(rem_sh - {1'b0, den_q}) : rem_sh[DenW-1:0];
      quo_d = {quo_q[NumW-2:0], fits};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
endmodule

FILE: sv/attention_state_merge_top.sv
// Channel  | Direction | Payload
// s_axis   | in        | tdata: part_lse, part_value; tlast: last_partial
// m_axis   | out       | tdata: merged_value, merged_lse
//
// A skipped partial takes only the decode step; any other partial also runs the 16
// steps of the exp2 loop on the shared multiplier, 4 multiplies and the update step.
// A last partial adds the 57-step divider, which runs beside log2.
// Reset is asynchronous and clears the running state to an empty group.
// A stalled result waits in the output register while the next request is taken.
module attention_state_merge_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [asm_pkg::DataW-1:0]     s_axis_tdata,  // part_lse, part_value
  input  logic                          s_axis_tlast,  // last_partial
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [asm_pkg::DataW-1:0]     m_axis_tdata   // merged_value, merged_lse
);
  import asm_pkg::*;

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001, ST_DEC  = 16'h0002, ST_EXPA = 16'h0004, ST_EXPB = 16'h0008,
    ST_EXPF = 16'h0010, ST_MD   = 16'h0020, ST_MSL  = 16'h0040, ST_MSH  = 16'h0080,
    ST_MV   = 16'h0100, ST_UPD  = 16'h0200, ST_FIN  = 16'h0400, ST_NORM = 16'h0800,
    ST_SQA  = 16'h1000, ST_SQB  = 16'h2000, ST_DIVW = 16'h4000, ST_OUT  = 16'h8000
  } state_e;

  state_e state_q, state_d;

  logic signed [LseW-1:0] max_q, max_d;
  logic [DenW-1:0]        den_q, den_d;
  logic signed [SumW-1:0] ws_q, ws_d;
  logic                   ovalid_q, ovalid_d;

  logic signed [LseW-1:0] s_q, s_d;
  logic signed [ValW-1:0] v_q, v_d;
  logic                   last_q, last_d;
  logic                   gt_q, gt_d;
  logic [7:0]             ip_q, ip_d;
  logic [15:0]            fp_q, fp_d;
  logic [3:0]             k_q, k_d;
  logic [30:0]            r_q, r_d;
  logic [16:0]            corr_q, corr_d, w_q, w_d;
  logic [56:0]            t_q, t_d;
  logic signed [SumW:0]   a_q, a_d;
  logic [30:0]            x_q, x_d;
  logic [4:0]             p_q, p_d;
  logic [15:0]            frac_q, frac_d;
  logic [ValW-1:0]        oval_q, oval_d;
  logic [LseW-1:0]        olse_q, olse_d;
  logic [ValW-1:0]        rval_q, rval_d;
  logic [LseW-1:0]        rlse_q, rlse_d;

  logic [31:0]     mul_a, mul_b;
  logic [63:0]     mul_p;
  logic            div_start, div_busy;
  logic [NumW-1:0] div_num, div_quo;

  logic              s_acc;
  logic              gt_c;
  logic              ws_neg, v_neg;
  logic [SumW-1:0]   ws_mag;
  logic [ValW-1:0]   v_mag;
  logic [LseW:0]     diff;
  logic [8:0]        shift;
  logic [63:0]       e_full;
  logic [16:0]       e_val;
  logic [26:0]       den_new;
  logic [56:0]       tm;
  logic [40:0]       rnd_s;
  logic [31:0]       rnd_v;
  logic signed [SumW+1:0] sum_new;
  logic [31:0]       sq_y;
  logic [ValW-1:0]   lim, res;
  logic signed [6:0] pm;
  logic signed [26:0] lse_w;

  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign ws_neg = ws_q[SumW-1];
  assign ws_mag = ws_neg ? SumW'(-ws_q) : SumW'(ws_q);
  assign v_neg  = v_q[ValW-1];
  assign v_mag  = v_neg ? ValW'(-v_q) : ValW'(v_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_EXPA: begin
        mul_a = 32'(r_q);
        mul_b = fp_q[4'd15 - k_q] ? 32'(ExpCoef[k_q]) : 32'(Q30One);
      end
      ST_MD:  begin mul_a = 32'(den_q);         mul_b = 32'(corr_q); end
      ST_MSL: begin mul_a = ws_mag[31:0];        mul_b = 32'(corr_q); end
      ST_MSH: begin mul_a = 32'(ws_mag[40:32]);  mul_b = 32'(corr_q); end
      ST_MV:  begin mul_a = v_mag;               mul_b = 32'(w_q);    end
      ST_SQA: begin mul_a = 32'(x_q);            mul_b = 32'(x_q);    end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  asm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign div_start = (state_q == ST_FIN) && (den_q != '0);
  assign div_num = NumW'({ws_mag, 16'b0}) + NumW'(den_q >> 1);

  asm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  assign gt_c   = $signed(s_q) > $signed(max_q);
  assign diff   = gt_c ? (LseW+1)'($signed(s_q) - $signed(max_q))
                       : (LseW+1)'($signed(max_q) - $signed(s_q));
  assign shift  = 9'(ip_q) + 9'd14;
  assign e_full = ({33'b0, r_q} + (64'd1 << (shift - 9'd1))) >> shift;
  assign e_val  = (shift >= 9'd63) ? 17'd0 : e_full[16:0];
  assign den_new = 27'((mul_p[41:0] + 42'h8000) >> 16) + 27'(w_q);
  assign tm     = t_q + {mul_p[24:0], 32'b0};
  assign rnd_s  = 41'((tm + 57'h8000) >> 16);
  assign rnd_v  = 32'((mul_p[47:0] + 48'h8000) >> 16);
  assign sum_new = (SumW+2)'(a_q) + (v_neg ? -(SumW+2)'($signed({1'b0, rnd_v}))
                                           : (SumW+2)'($signed({1'b0, rnd_v})));
  assign sq_y   = mul_p[61:30];
  assign lim    = ws_neg ? 32'h8000_0000 : 32'h7fff_ffff;
  assign res    = (div_quo > NumW'(lim)) ? lim : div_quo[31:0];
  assign pm     = $signed({2'b0, p_q}) - 7'sd16;
  assign lse_w  = 27'(max_q) + {{4{pm[6]}}, pm, 16'b0} + {11'b0, frac_q};

  always_comb begin
    state_d  = state_q;
    max_d = max_q;  den_d = den_q;  ws_d = ws_q;
    ovalid_d = ovalid_q;
    s_d = s_q;  v_d = v_q;  last_d = last_q;
    gt_d = gt_q;  ip_d = ip_q;  fp_d = fp_q;  k_d = k_q;  r_d = r_q;
    corr_d = corr_q;  w_d = w_q;  t_d = t_q;  a_d = a_q;
    x_d = x_q;  p_d = p_q;  frac_d = frac_q;
    oval_d = oval_q;  olse_d = olse_q;  rval_d = rval_q;  rlse_d = rlse_q;
    if (m_axis_tvalid && m_axis_tready) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          s_d     = s_axis_tdata[LseW-1:0];
          v_d     = s_axis_tdata[DataW-1:LseW];
          last_d  = s_axis_tlast;
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        gt_d = gt_c;
        if (s_q == LseNegInf) begin
          state_d = last_q ? ST_FIN : ST_IDLE;
        end else begin
          ip_d    = diff[23:16];
          fp_d    = diff[15:0];
          r_d     = Q30One;
          k_d     = '0;
          state_d = ST_EXPA;
        end
      end
      ST_EXPA: state_d = ST_EXPB;
      ST_EXPB: begin
        r_d = 31'((mul_p + 64'h2000_0000) >> 30);
        k_d = k_q + 4'd1;
        state_d = (k_q == 4'd15) ? ST_EXPF : ST_EXPA;
      end
      ST_EXPF: begin
        corr_d  = gt_q ? e_val : QOne;
        w_d     = gt_q ? QOne : e_val;
        state_d = ST_MD;
      end
      ST_MD: state_d = ST_MSL;
      ST_MSL: begin
        den_d   = (den_new > 27'((1 << DenW) - 1)) ? {DenW{1'b1}} : den_new[DenW-1:0];
        state_d = ST_MSH;
      end
      ST_MSH: begin
        t_d     = 57'(mul_p[48:0]);
        state_d = ST_MV;
      end
      ST_MV: begin
        a_d     = ws_neg ? -$signed({1'b0, rnd_s}) : $signed({1'b0, rnd_s});
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (sum_new > (SumW+2)'($signed({1'b0, {(SumW-1){1'b1}}}))) begin
          ws_d = {1'b0, {(SumW-1){1'b1}}};
        end else if (sum_new < -(SumW+2)'($signed({1'b0, 1'b1, {(SumW-1){1'b0}}}))) begin
          ws_d = {1'b1, {(SumW-1){1'b0}}};
        end else begin
          ws_d = sum_new[SumW-1:0];
        end
        if (gt_q) begin
          max_d = s_q;
        end
        state_d = last_q ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (den_q == '0) begin
          rval_d  = '0;
          rlse_d  = LseNegInf;
          state_d = ST_OUT;
        end else begin
          x_d     = 31'(den_q);
          p_d     = 5'd30;
          k_d     = '0;
          frac_d  = '0;
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (x_q[30]) begin
          state_d = ST_SQA;
        end else begin
          x_d = {x_q[29:0], 1'b0};
          p_d = p_q - 5'd1;
        end
      end
      ST_SQA: state_d = ST_SQB;
      ST_SQB: begin
        frac_d  = {frac_q[14:0], sq_y[31]};
        x_d     = sq_y[31] ? sq_y[31:1] : sq_y[30:0];
        k_d     = k_q + 4'd1;
        state_d = (k_q == 4'd15) ? ST_DIVW : ST_SQA;
      end
      ST_DIVW: begin
        if (!div_busy) begin
          rval_d = ws_neg ? ValW'(-res) : res;
          if (lse_w > 27'(LsePosMax)) begin
            rlse_d = LsePosMax;
          end else if (lse_w <= 27'(LseNegInf)) begin
            rlse_d = LseNegInf + LseW'(1);
          end else begin
            rlse_d = lse_w[LseW-1:0];
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          oval_d   = rval_q;
          olse_d   = rlse_q;
          ovalid_d = 1'b1;
          max_d    = LseNegInf;
          den_d    = '0;
          ws_d     = '0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      max_q    <= LseNegInf;
      den_q    <= '0;
      ws_q     <= '0;
      ovalid_q <= 1'b0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      max_q    <= max_d;
      den_q    <= den_d;
      ws_q     <= ws_d;
      ovalid_q <= ovalid_d;
      k_q      <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;  v_q <= v_d;  last_q <= last_d;
    gt_q <= gt_d;  ip_q <= ip_d;  fp_q <= fp_d;  r_q <= r_d;
    corr_q <= corr_d;  w_q <= w_d;  t_q <= t_d;  a_q <= a_d;
    x_q <= x_d;  p_q <= p_d;  frac_q <= frac_d;
    oval_q <= oval_d;  olse_q <= olse_d;  rval_q <= rval_d;  rlse_q <= rlse_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {olse_q, oval_q};

  // The running state returns to an empty group once a result is loaded.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && (!ovalid_q || m_axis_tready)) |=>
      (den_q == '0 && ws_q == '0 && max_q == LseNegInf))
    else $error("merge state not cleared after result");

  // The exp2 product never grows past one.
  a_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXPA) |-> (r_q <= Q30One))
    else $error("exp2 accumulator above one");

  // A skipped partial leaves the denominator untouched.
  a_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tdata[LseW-1:0] == LseNegInf && !s_axis_tlast) |=> ##1
      (den_q == $past(den_q, 2)))
    else $error("skipped partial changed the denominator");
endmodule
